>>> rtl/chip8_cpu_core_top_assert.svh
// assertion macros used by the core sequencer
`ifndef CHIP8_CPU_CORE_TOP_ASSERT_SVH
`define CHIP8_CPU_CORE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define C8_ASSERT_NOW(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define C8_ASSERT_NXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/c8cpu_pkg.sv
// shared types, constants and step codes of the chip8 core
package c8cpu_pkg;

    localparam int MEMORY_BYTES  = 4096;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_PIXELS = 2048;
    localparam int PROGRAM_START = 512;
    localparam int STACK_BASE    = 3744;
    localparam int FONT_BASE     = 0;

    localparam int ADDR_W = $clog2(MEMORY_BYTES);
    localparam int PIX_W  = $clog2(SCREEN_PIXELS);

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_READ  = 2'd1;
    localparam logic [1:0] FN_PIXEL = 2'd2;
    localparam logic [1:0] FN_EXEC  = 2'd3;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEB  = 4'h3;
    localparam logic [3:0] OP_SNEB = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDB  = 4'h6;
    localparam logic [3:0] OP_ADDB = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] LO_CLS  = 8'hE0;
    localparam logic [7:0] LO_RET  = 8'hEE;
    localparam logic [7:0] LO_SKP  = 8'h9E;
    localparam logic [7:0] LO_SKNP = 8'hA1;
    localparam logic [7:0] FX_GDT  = 8'h07;
    localparam logic [7:0] FX_WKEY = 8'h0A;
    localparam logic [7:0] FX_SDT  = 8'h15;
    localparam logic [7:0] FX_SST  = 8'h18;
    localparam logic [7:0] FX_ADDI = 8'h1E;
    localparam logic [7:0] FX_FONT = 8'h29;
    localparam logic [7:0] FX_BCD  = 8'h33;
    localparam logic [7:0] FX_STR  = 8'h55;
    localparam logic [7:0] FX_LDR  = 8'h65;

    localparam logic [4:0] ST_CLR  = 5'd0;
    localparam logic [4:0] ST_IDLE = 5'd1;
    localparam logic [4:0] ST_RDM  = 5'd2;
    localparam logic [4:0] ST_RDP  = 5'd3;
    localparam logic [4:0] ST_F1   = 5'd4;
    localparam logic [4:0] ST_F2   = 5'd5;
    localparam logic [4:0] ST_RX   = 5'd6;
    localparam logic [4:0] ST_RY   = 5'd7;
    localparam logic [4:0] ST_EX   = 5'd8;
    localparam logic [4:0] ST_RET1 = 5'd9;
    localparam logic [4:0] ST_RET2 = 5'd10;
    localparam logic [4:0] ST_CALL = 5'd11;
    localparam logic [4:0] ST_WX   = 5'd12;
    localparam logic [4:0] ST_WF   = 5'd13;
    localparam logic [4:0] ST_DR   = 5'd14;
    localparam logic [4:0] ST_DB   = 5'd15;
    localparam logic [4:0] ST_DP   = 5'd16;
    localparam logic [4:0] ST_DW   = 5'd17;
    localparam logic [4:0] ST_B1   = 5'd18;
    localparam logic [4:0] ST_B2   = 5'd19;
    localparam logic [4:0] ST_ST   = 5'd20;
    localparam logic [4:0] ST_LD   = 5'd21;
    localparam logic [4:0] ST_OUT  = 5'd22;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data;
        logic [15:0]       keys;
        logic [7:0]        random_byte;
        logic [7:0]        delay_now;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [7:0]        read_data;
        logic              draw_flag;
        logic              waiting_key;
        logic              delay_set_valid;
        logic [7:0]        delay_set_value;
        logic              sound_set_valid;
        logic [7:0]        sound_set_value;
    } t_out;

    typedef struct packed {
        logic [4:0] step;
        logic       accept;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] op;
        logic [3:0] alu_n;
        logic [7:0] lo;
        logic       is_cls;
        logic       is_ret;
        logic       n_zero;
        logic       x_zero;
        logic       clr_last;
        logic       col_last;
        logic       row_last;
        logic       cnt_eq_x;
    } t_stat;

endpackage

>>> rtl/chip8_cpu_core_top.sv
// chip8 core top level: sequencer and datapath
// memory write goes straight to o_done; memory or pixel read passes a read step; instructions pass fetch,
// register read and execute; display clear walks the whole frame store, sprite draw each sprite pixel
// register store and load move one register per cycle; one transaction in flight at a time
// o_done strobes one cycle per transaction; the receiver always takes it
// after reset busy stays high while the frame store is cleared
module chip8_cpu_core_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  c8cpu_pkg::t_in  i_item,
    output logic            busy,
    output logic            o_done,
    output c8cpu_pkg::t_out o_result
);
    import c8cpu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    c8cpu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_item.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    c8cpu_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

>>> rtl/c8cpu_ctrl.sv
// sequencer of the chip8 core: one step per cycle over fetch, decode and execute
module c8cpu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_func,
    input  c8cpu_pkg::t_stat i_stat,
    output c8cpu_pkg::t_cmd  o_cmd,
    output logic             busy,
    output logic             o_done
);
    import c8cpu_pkg::*;

    logic [4:0] r_state, n_state;
    logic       r_clr_ex, n_clr_ex;

    always_comb begin
        n_state  = r_state;
        n_clr_ex = r_clr_ex;
        case (r_state)
            ST_CLR: begin
                if (i_stat.clr_last) begin
                    n_state  = r_clr_ex ? ST_OUT : ST_IDLE;
                    n_clr_ex = 1'b0;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_func)
                        FN_WRITE: n_state = ST_OUT;
                        FN_READ:  n_state = ST_RDM;
                        FN_PIXEL: n_state = ST_RDP;
                        default:  n_state = ST_F1;
                    endcase
                end
            end
            ST_RDM, ST_RDP, ST_CALL, ST_WF, ST_B2, ST_RET2: n_state = ST_OUT;
            ST_F1:   n_state = ST_F2;
            ST_F2:   n_state = ST_RX;
            ST_RX:   n_state = ST_RY;
            ST_RY:   n_state = ST_EX;
            ST_EX: begin
                n_state = ST_OUT;
                case (i_stat.op)
                    OP_SYS: begin
                        if (i_stat.is_cls) begin
                            n_state  = ST_CLR;
                            n_clr_ex = 1'b1;
                        end else if (i_stat.is_ret) begin
                            n_state = ST_RET1;
                        end
                    end
                    OP_CALL: n_state = ST_CALL;
                    OP_ALU: begin
                        if (i_stat.alu_n inside {ALU_ADD, ALU_SUB, ALU_SBN}) begin
                            n_state = ST_WF;
                        end else if (i_stat.alu_n inside {ALU_SHR, ALU_SHL}) begin
                            n_state = ST_WX;
                        end
                    end
                    OP_DRW:  n_state = i_stat.n_zero ? ST_WF : ST_DR;
                    OP_MISC: begin
                        case (i_stat.lo)
                            FX_BCD:  n_state = ST_B1;
                            FX_STR:  n_state = i_stat.x_zero ? ST_OUT : ST_ST;
                            FX_LDR:  n_state = ST_LD;
                            FX_ADDI: n_state = ST_WF;
                            default: n_state = ST_OUT;
                        endcase
                    end
                    default: n_state = ST_OUT;
                endcase
            end
            ST_RET1: n_state = ST_RET2;
            ST_WX:   n_state = ST_WF;
            ST_DR:   n_state = ST_DB;
            ST_DB:   n_state = ST_DP;
            ST_DP:   n_state = ST_DW;
            ST_DW: begin
                if (!i_stat.col_last) begin
                    n_state = ST_DP;
                end else begin
                    n_state = i_stat.row_last ? ST_WF : ST_DR;
                end
            end
            ST_B1:   n_state = ST_B2;
            ST_ST, ST_LD: begin
                if (i_stat.cnt_eq_x) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr_ex <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr_ex <= n_clr_ex;
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = (r_state == ST_OUT);
    assign o_cmd.step    = r_state;
    assign o_cmd.accept  = start && (r_state == ST_IDLE);

    `include "chip8_cpu_core_top_assert.svh"

    `C8_ASSERT_NXT(a_accept_leaves_idle, start && r_state == ST_IDLE, r_state != ST_IDLE, "accepted transaction left the sequencer idle")
    `C8_ASSERT_NXT(a_out_one_cycle, r_state == ST_OUT, r_state == ST_IDLE, "result strobe longer than one cycle")
    `C8_ASSERT_NXT(a_boot_clear_ends_idle, r_state == ST_CLR && i_stat.clr_last && !r_clr_ex, r_state == ST_IDLE, "clearing pass after reset did not end idle")
    `C8_ASSERT_NOW(a_clr_ex_only_clearing, r_clr_ex, r_state == ST_CLR, "clear return flag set outside clearing pass")

endmodule

>>> rtl/c8cpu_dp.sv
// datapath of the chip8 core: registers, main memory, frame store and alu
module c8cpu_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  c8cpu_pkg::t_cmd  i_cmd,
    input  c8cpu_pkg::t_in   i_item,
    output c8cpu_pkg::t_stat o_stat,
    output c8cpu_pkg::t_out  o_result
);
    import c8cpu_pkg::*;

    logic [7:0]        r_mem [MEMORY_BYTES];
    logic [7:0]        r_mem_q;
    logic              r_fb [SCREEN_PIXELS];
    logic              r_f_q;
    logic [7:0]        r_rf [16];
    logic [15:0]       r_rf_vld;
    logic [7:0]        r_rf_q;

    t_in               r_in;
    logic [7:0]        r_hi, r_lo, r_vx, r_vy, r_res, r_spr, r_tmp;
    logic              r_flag;
    logic [ADDR_W-1:0] r_pc;
    logic [15:0]       r_index;
    logic [5:0]        r_sp;
    logic [3:0]        r_row, r_cnt;
    logic [2:0]        r_col;
    logic [PIX_W-1:0]  r_pcnt;
    logic [7:0]        r_rd, r_dval, r_sval;
    logic              r_draw, r_wait, r_dv, r_sv;

    logic [ADDR_W-1:0] m_ra, m_wa;
    logic [7:0]        m_wd;
    logic              m_we;
    logic [3:0]        rf_ra, rf_wa;
    logic [7:0]        rf_wd;
    logic              rf_we;
    logic [PIX_W-1:0]  f_ra, f_wa;
    logic              f_wd, f_we;

    logic [3:0]        x, y, n, op;
    logic [ADDR_W-1:0] nnn, ia, pc2, stk, n_pc;
    logic [5:0]        sp_dn;
    logic [7:0]        alu_res, bcd_h, bcd_t, bcd_o, rem;
    logic              alu_flag, down, sbit;
    logic [8:0]        sum9;
    logic [15:0]       sum_i, tens_p;
    logic [3:0]        low_key;
    logic [31:0]       pix_lin, pix_addr;
    logic [PIX_W-1:0]  pix_idx;
    logic              in_range;

    assign op    = r_hi[7:4];
    assign x     = r_hi[3:0];
    assign y     = r_lo[7:4];
    assign n     = r_lo[3:0];
    assign nnn   = {x, r_lo};
    assign ia    = r_index[ADDR_W-1:0];
    assign pc2   = r_pc + ADDR_W'(2);
    assign sp_dn = r_sp - 6'd2;
    assign stk   = ADDR_W'(STACK_BASE) + ADDR_W'(r_sp);
    assign sum9  = {1'b0, r_vx} + {1'b0, r_vy};
    assign sum_i = r_index + {8'd0, r_vx};
    assign down  = (r_vx < 8'd16) && r_in.keys[r_vx[3:0]];
    assign sbit  = r_spr[3'd7 - r_col];

    assign pix_lin  = 32'(r_vx) + 32'(r_col) + (32'(r_vy) + 32'(r_row)) * 32'(SCREEN_WIDTH);
    assign pix_idx  = pix_lin[PIX_W-1:0];
    assign pix_addr = 32'(r_in.address);
    assign in_range = (pix_addr < 32'(SCREEN_PIXELS));

    // decimal digits: hundreds by compare, tens by reciprocal multiply
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h = 8'd2;
            rem   = r_vx - 8'd200;
        end else if (r_vx >= 8'd100) begin
            bcd_h = 8'd1;
            rem   = r_vx - 8'd100;
        end else begin
            bcd_h = 8'd0;
            rem   = r_vx;
        end
        tens_p = 16'(rem) * 16'd205;
        bcd_t  = {3'd0, tens_p[15:11]};
        bcd_o  = rem - 8'(bcd_t * 8'd10);
    end

    always_comb begin
        low_key = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (r_in.keys[i]) begin
                low_key = 4'(i);
            end
        end
    end

    always_comb begin
        alu_res  = r_vy;
        alu_flag = 1'b0;
        case (n)
            ALU_OR:  alu_res = r_vx | r_vy;
            ALU_AND: alu_res = r_vx & r_vy;
            ALU_XOR: alu_res = r_vx ^ r_vy;
            ALU_ADD: begin
                alu_res  = sum9[7:0];
                alu_flag = sum9[8];
            end
            ALU_SUB: begin
                alu_res  = r_vx - r_vy;
                alu_flag = (r_vx >= r_vy);
            end
            ALU_SHR: begin
                alu_res  = {1'b0, r_vy[7:1]};
                alu_flag = r_vy[0];
            end
            ALU_SBN: begin
                alu_res  = r_vy - r_vx;
                alu_flag = (r_vy >= r_vx);
            end
            ALU_SHL: begin
                alu_res  = {r_vy[6:0], 1'b0};
                alu_flag = r_vy[7];
            end
            default: alu_res = r_vy;
        endcase
    end

    always_comb begin
        n_pc = pc2;
        case (op)
            OP_JP:   n_pc = nnn;
            OP_SEB:  n_pc = (r_vx == r_lo) ? pc2 + ADDR_W'(2) : pc2;
            OP_SNEB: n_pc = (r_vx != r_lo) ? pc2 + ADDR_W'(2) : pc2;
            OP_SER:  n_pc = (n == 4'd0 && r_vx == r_vy) ? pc2 + ADDR_W'(2) : pc2;
            OP_SNER: n_pc = (r_vx != r_vy) ? pc2 + ADDR_W'(2) : pc2;
            OP_JPV0: n_pc = nnn + ADDR_W'(r_rf_q);
            OP_KEY: begin
                if ((r_lo == LO_SKP && down) || (r_lo == LO_SKNP && !down)) begin
                    n_pc = pc2 + ADDR_W'(2);
                end
            end
            OP_MISC: begin
                if (r_lo == FX_WKEY && r_in.keys == 16'd0) begin
                    n_pc = r_pc;
                end
            end
            default: n_pc = pc2;
        endcase
    end

    always_comb begin
        m_ra  = r_pc;
        m_we  = 1'b0;
        m_wa  = ia;
        m_wd  = r_rf_q;
        rf_ra = 4'd0;
        rf_we = 1'b0;
        rf_wa = x;
        rf_wd = r_res;
        f_ra  = pix_idx;
        f_we  = 1'b0;
        f_wa  = pix_idx;
        f_wd  = ~r_f_q;
        case (i_cmd.step)
            ST_CLR: begin
                f_we = 1'b1;
                f_wa = r_pcnt;
                f_wd = 1'b0;
            end
            ST_IDLE: begin
                m_ra = (i_item.func == FN_EXEC) ? r_pc : i_item.address;
                m_we = i_cmd.accept && (i_item.func == FN_WRITE);
                m_wa = i_item.address;
                m_wd = i_item.data;
                f_ra = PIX_W'(32'(i_item.address));
            end
            ST_F1:  m_ra = r_pc + ADDR_W'(1);
            ST_F2:  rf_ra = r_hi[3:0];
            ST_RX:  rf_ra = y;
            ST_RY:  rf_ra = 4'd0;
            ST_EX: begin
                case (op)
                    OP_SYS:  m_ra = ADDR_W'(STACK_BASE) + ADDR_W'(sp_dn);
                    OP_CALL: begin
                        m_we = 1'b1;
                        m_wa = stk;
                        m_wd = {4'd0, r_pc[11:8]};
                    end
                    OP_LDB: begin
                        rf_we = 1'b1;
                        rf_wd = r_lo;
                    end
                    OP_ADDB: begin
                        rf_we = 1'b1;
                        rf_wd = r_vx + r_lo;
                    end
                    OP_ALU: begin
                        rf_we = (n inside {[ALU_MOV:ALU_SBN], ALU_SHL});
                        rf_wa = (n inside {ALU_SHR, ALU_SHL}) ? y : x;
                        rf_wd = alu_res;
                    end
                    OP_RND: begin
                        rf_we = 1'b1;
                        rf_wd = r_in.random_byte & r_lo;
                    end
                    OP_MISC: begin
                        case (r_lo)
                            FX_GDT: begin
                                rf_we = 1'b1;
                                rf_wd = r_in.delay_now;
                            end
                            FX_WKEY: begin
                                rf_we = (r_in.keys != 16'd0);
                                rf_wd = {4'd0, low_key};
                            end
                            FX_BCD: begin
                                m_we = 1'b1;
                                m_wd = bcd_h;
                            end
                            FX_STR: begin
                                m_we  = 1'b1;
                                rf_ra = 4'd1;
                            end
                            FX_LDR:  m_ra = ia;
                            default: m_we = 1'b0;
                        endcase
                    end
                    default: m_we = 1'b0;
                endcase
            end
            ST_RET1: m_ra = stk + ADDR_W'(1);
            ST_CALL: begin
                m_we = 1'b1;
                m_wa = stk + ADDR_W'(1);
                m_wd = r_pc[7:0];
            end
            ST_WX: begin
                rf_we = 1'b1;
                rf_wa = x;
            end
            ST_WF: begin
                rf_we = 1'b1;
                rf_wa = 4'hF;
                rf_wd = {7'd0, r_flag};
            end
            ST_DR: m_ra = ia + ADDR_W'(r_row);
            ST_DW: f_we = sbit;
            ST_B1: begin
                m_we = 1'b1;
                m_wa = ia + ADDR_W'(1);
                m_wd = bcd_t;
            end
            ST_B2: begin
                m_we = 1'b1;
                m_wa = ia + ADDR_W'(2);
                m_wd = bcd_o;
            end
            ST_ST: begin
                m_we  = 1'b1;
                rf_ra = r_cnt + 4'd1;
            end
            ST_LD: begin
                m_ra  = ia + ADDR_W'(1);
                rf_we = 1'b1;
                rf_wa = r_cnt;
                rf_wd = r_mem_q;
            end
            default: m_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_wa] <= m_wd;
        end
        r_mem_q <= r_mem[m_ra];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_fb[f_wa] <= f_wd;
        end
        r_f_q <= r_fb[f_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        r_rf_q <= r_rf_vld[rf_ra] ? r_rf[rf_ra] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_pc     <= ADDR_W'(PROGRAM_START);
            r_index  <= '0;
            r_sp     <= '0;
            r_pcnt   <= '0;
        end else begin
            if (rf_we) begin
                r_rf_vld[rf_wa] <= 1'b1;
            end
            case (i_cmd.step)
                ST_CLR: r_pcnt <= r_pcnt + PIX_W'(1);
                ST_EX: begin
                    if (op != OP_CALL && !(op == OP_SYS && r_lo == LO_RET && x == 4'd0)) begin
                        r_pc <= n_pc;
                    end
                    if (op == OP_SYS && r_lo == LO_RET && x == 4'd0) begin
                        r_sp <= sp_dn;
                    end
                    if (op == OP_LDI) begin
                        r_index <= {4'd0, nnn};
                    end
                    if (op == OP_MISC) begin
                        case (r_lo)
                            FX_ADDI: r_index <= (sum_i > 16'hFFF) ? (sum_i & 16'hFFF) : sum_i;
                            FX_FONT: r_index <= 16'(FONT_BASE) + 16'(r_vx) * 16'd5;
                            FX_STR:  r_index <= r_index + 16'd1;
                            default: r_index <= r_index;
                        endcase
                    end
                end
                ST_RET2: r_pc <= ADDR_W'({r_tmp, r_mem_q} + 16'd2);
                ST_CALL: begin
                    r_sp <= r_sp + 6'd2;
                    r_pc <= nnn;
                end
                ST_ST, ST_LD: r_index <= r_index + 16'd1;
                default: r_pc <= r_pc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.step)
            ST_IDLE: begin
                if (i_cmd.accept) begin
                    r_in   <= i_item;
                    r_rd   <= '0;
                    r_draw <= 1'b0;
                    r_wait <= 1'b0;
                    r_dv   <= 1'b0;
                    r_dval <= '0;
                    r_sv   <= 1'b0;
                    r_sval <= '0;
                end
            end
            ST_RDM: r_rd <= r_mem_q;
            ST_RDP: r_rd <= {7'd0, r_f_q & in_range};
            ST_F1:  r_hi <= r_mem_q;
            ST_F2:  r_lo <= r_mem_q;
            ST_RX:  r_vx <= r_rf_q;
            ST_RY:  r_vy <= r_rf_q;
            ST_EX: begin
                r_res  <= alu_res;
                r_flag <= alu_flag;
                r_row  <= '0;
                r_cnt  <= '0;
                case (op)
                    OP_SYS: r_draw <= (r_lo == LO_CLS && x == 4'd0);
                    OP_DRW: begin
                        r_draw <= 1'b1;
                        r_flag <= 1'b0;
                    end
                    OP_MISC: begin
                        case (r_lo)
                            FX_WKEY: r_wait <= (r_in.keys == 16'd0);
                            FX_SDT: begin
                                r_dv   <= 1'b1;
                                r_dval <= r_vx;
                            end
                            FX_SST: begin
                                r_sv   <= 1'b1;
                                r_sval <= r_vx;
                            end
                            FX_ADDI: r_flag <= (sum_i > 16'hFFF);
                            FX_STR:  r_cnt  <= 4'd1;
                            default: r_cnt  <= 4'd0;
                        endcase
                    end
                    default: r_draw <= 1'b0;
                endcase
            end
            ST_RET1: r_tmp <= r_mem_q;
            ST_DB: begin
                r_spr <= r_mem_q;
                r_col <= '0;
            end
            ST_DW: begin
                r_flag <= r_flag | (sbit & r_f_q);
                r_col  <= r_col + 3'd1;
                if (r_col == 3'd7) begin
                    r_row <= r_row + 4'd1;
                end
            end
            ST_ST, ST_LD: r_cnt <= r_cnt + 4'd1;
            default: r_flag <= r_flag;
        endcase
    end

    assign o_stat.func     = i_item.func;
    assign o_stat.op       = op;
    assign o_stat.alu_n    = n;
    assign o_stat.lo       = r_lo;
    assign o_stat.is_cls   = (x == 4'd0) && (r_lo == LO_CLS);
    assign o_stat.is_ret   = (x == 4'd0) && (r_lo == LO_RET);
    assign o_stat.n_zero   = (n == 4'd0);
    assign o_stat.x_zero   = (x == 4'd0);
    assign o_stat.clr_last = &r_pcnt;
    assign o_stat.col_last = (r_col == 3'd7);
    assign o_stat.row_last = (r_row == n - 4'd1);
    assign o_stat.cnt_eq_x = (r_cnt == x);

    assign o_result.pc              = r_pc;
    assign o_result.read_data       = r_rd;
    assign o_result.draw_flag       = r_draw;
    assign o_result.waiting_key     = r_wait;
    assign o_result.delay_set_valid = r_dv;
    assign o_result.delay_set_value = r_dval;
    assign o_result.sound_set_valid = r_sv;
    assign o_result.sound_set_value = r_sval;

endmodule
